FILE: rtl/core/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants of the terminal line discipline
// Holds the command format passed from the front end to the back end, the
// result format, the character codes and the configuration register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

    // Line store geometry; the default is also the largest supported size.
    localparam int LINE_BYTES_DEF = 64;
    localparam int CMD_IDX_W      = 6;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register map.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_EN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CANONICAL_EN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_EN       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NL_ECHO_EN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERRUPT_CHR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_KILL_CHR      = 3'd5;

    localparam logic [7:0] INTERRUPT_CHR_RST = 8'd128;
    localparam logic [7:0] KILL_CHR_RST      = 8'd129;

    // Character codes.
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_CARET = 8'h5E;
    localparam logic [7:0] CHR_C     = 8'h43;
    localparam logic [7:0] CHR_K     = 8'h4B;

    // Signal codes carried with a result.
    typedef logic [1:0] sig_t;
    localparam sig_t SIG_NONE = 2'd0;
    localparam sig_t SIG_INT  = 2'd1;
    localparam sig_t SIG_KILL = 2'd2;

    // Command kinds.
    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_SIGNAL,
        CMD_FLUSH,
        CMD_PASS
    } cmd_op_t;

    // One command. For a flush, idx is the line length before the newline
    // and echo is the newline echo flag.
    typedef struct packed {
        cmd_op_t              op;
        logic [7:0]           data;
        logic [CMD_IDX_W-1:0] idx;
        logic                 store;
        logic                 echo;
        sig_t                 sig;
    } cmd_t;

    // Queue status seen by front and back end.
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    // One result beat.
    typedef struct packed {
        logic       last;
        sig_t       sig;
        logic [7:0] echo_byte;
        logic       echo_valid;
        logic [7:0] reader_byte;
        logic       reader_valid;
    } result_t;

    localparam int TDATA_W = 24;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_ONE,
        B_SIG2,
        B_FLUSH
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/tld_queue.sv
// ----------------------------------------------------------------------------
// tld_queue: command queue between front and back end
// A small FIFO of commands so that classification and result generation
// can stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tld_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire tld_pkg::cmd_t          push_cmd,
    input  wire logic                   pop,
    output tld_pkg::cmd_t               head_cmd,
    output tld_pkg::queue_status_t      status
);
    import tld_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/core/tld_front.sv
// ----------------------------------------------------------------------------
// tld_front: input classifier of the terminal line discipline
// Holds the mode registers and the line length, classifies each typed byte
// and queues one command for the back end when the byte yields a beat or a store write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tld_front #(
    parameter int LINE_BYTES = tld_pkg::LINE_BYTES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Typed bytes
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    // Configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    // Command queue
    input  wire tld_pkg::queue_status_t        q_status,
    output logic                               push,
    output tld_pkg::cmd_t                      push_cmd
);
    import tld_pkg::*;

    localparam int IDX_W = $clog2(LINE_BYTES);

    logic       sig_en_reg, canon_en_reg, echo_en_reg, nl_echo_en_reg;
    logic [7:0] int_chr_reg, kill_chr_reg;
    logic [IDX_W-1:0] count_reg, count_next;

    logic accept;
    logic sig_hit;
    logic has_room;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_en_reg     <= 1'b1;
            canon_en_reg   <= 1'b1;
            echo_en_reg    <= 1'b1;
            nl_echo_en_reg <= 1'b1;
            int_chr_reg    <= INTERRUPT_CHR_RST;
            kill_chr_reg   <= KILL_CHR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SIGNAL_EN:     sig_en_reg     <= cfg_data[0];
                REG_CANONICAL_EN:  canon_en_reg   <= cfg_data[0];
                REG_ECHO_EN:       echo_en_reg    <= cfg_data[0];
                REG_NL_ECHO_EN:    nl_echo_en_reg <= cfg_data[0];
                REG_INTERRUPT_CHR: int_chr_reg    <= cfg_data;
                REG_KILL_CHR:      kill_chr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // A byte is taken whenever the queue has a free slot.
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    assign sig_hit  = sig_en_reg && ((s_tdata == int_chr_reg) || (s_tdata == kill_chr_reg));
    assign has_room = (count_reg < IDX_W'(LINE_BYTES - 1));

    // Classification of the typed byte into a command and a new line length.
    always_comb begin
        push_cmd       = '0;
        push_cmd.op    = CMD_PASS;
        push_cmd.data  = s_tdata;
        push_cmd.idx   = CMD_IDX_W'(count_reg);
        push           = 1'b0;
        count_next     = count_reg;
        if (accept) begin
            if (sig_hit) begin
                // Interrupt wins when both characters match.
                push_cmd.op   = CMD_SIGNAL;
                push_cmd.sig  = (s_tdata == int_chr_reg) ? SIG_INT : SIG_KILL;
                push_cmd.echo = echo_en_reg;
                push          = 1'b1;
                count_next    = '0;
            end else if (canon_en_reg) begin
                if (s_tdata == CHR_BS) begin
                    // Backspace on an empty line does nothing at all.
                    if (count_reg != '0) begin
                        count_next    = count_reg - 1'b1;
                        push_cmd.op   = CMD_CHAR;
                        push_cmd.echo = 1'b1;
                        push          = echo_en_reg;
                    end
                end else if ((s_tdata == CHR_LF) || (s_tdata == CHR_CR)) begin
                    push_cmd.op   = CMD_FLUSH;
                    push_cmd.echo = nl_echo_en_reg;
                    push          = 1'b1;
                    count_next    = '0;
                end else begin
                    // Beyond the last free slot the byte is dropped, but still echoed when echo is enabled.
                    push_cmd.op    = CMD_CHAR;
                    push_cmd.store = has_room;
                    push_cmd.echo  = echo_en_reg;
                    push           = has_room || echo_en_reg;
                    if (has_room) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end else begin
                push_cmd.op   = CMD_PASS;
                push_cmd.echo = (s_tdata == CHR_LF) ? nl_echo_en_reg : echo_en_reg;
                push          = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tld_back.sv
// ----------------------------------------------------------------------------
// tld_back: result generator of the terminal line discipline
// Executes queued commands in order: writes the line store, emits echo,
// signal and pass-through beats, and drains the line on a flush at one
// beat per cycle from the line store while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tld_back #(
    parameter int LINE_BYTES = tld_pkg::LINE_BYTES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Command queue
    input  wire tld_pkg::queue_status_t   q_status,
    input  wire tld_pkg::cmd_t            head_cmd,
    output logic                          pop,
    // Result beats
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output tld_pkg::result_t              m_result
);
    import tld_pkg::*;

    localparam int IDX_W = $clog2(LINE_BYTES);

    back_state_t state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       line_mem [LINE_BYTES];
    logic [7:0]       rd_data_reg;
    logic             mem_we;

    logic    out_valid_reg;
    result_t out_reg;
    logic    out_free;
    logic    load;
    result_t res;
    logic    at_end;

    assign out_free = !out_valid_reg || m_tready;
    assign at_end   = (ptr_reg == cur_reg.idx[IDX_W-1:0]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_status.valid) begin
                    case (head_cmd.op)
                        CMD_CHAR:   state_next = head_cmd.echo ? B_ONE : B_IDLE;
                        CMD_FLUSH:  state_next = B_FLUSH;
                        default:    state_next = B_ONE;
                    endcase
                end
            end
            B_ONE: begin
                if (out_free) begin
                    state_next = (cur_reg.op == CMD_SIGNAL && cur_reg.echo) ? B_SIG2 : B_IDLE;
                end
            end
            B_SIG2: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            B_FLUSH: begin
                if (out_free && at_end) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer: queue pop, store write, read address, beat.
    always_comb begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        load     = 1'b0;
        cur_next = cur_reg;
        ptr_next = ptr_reg;
        rd_addr  = ptr_reg;
        res      = '0;
        case (state_reg)
            B_IDLE: begin
                pop      = q_status.valid;
                mem_we   = q_status.valid && (head_cmd.op == CMD_CHAR) && head_cmd.store;
                cur_next = q_status.valid ? head_cmd : cur_reg;
                // Prefetch the first line byte for a possible flush.
                ptr_next = '0;
                rd_addr  = '0;
            end
            B_ONE: begin
                load = out_free;
                case (cur_reg.op)
                    CMD_SIGNAL: begin
                        res.sig        = cur_reg.sig;
                        res.echo_valid = cur_reg.echo;
                        res.echo_byte  = cur_reg.echo ? CHR_CARET : 8'h00;
                        res.last       = !cur_reg.echo;
                    end
                    CMD_PASS: begin
                        res.reader_valid = 1'b1;
                        res.reader_byte  = cur_reg.data;
                        res.echo_valid   = cur_reg.echo;
                        res.echo_byte    = cur_reg.echo ? cur_reg.data : 8'h00;
                        res.last         = 1'b1;
                    end
                    default: begin
                        res.echo_valid = 1'b1;
                        res.echo_byte  = cur_reg.data;
                        res.last       = 1'b1;
                    end
                endcase
            end
            B_SIG2: begin
                load           = out_free;
                res.echo_valid = 1'b1;
                res.echo_byte  = (cur_reg.sig == SIG_INT) ? CHR_C : CHR_K;
                res.last       = 1'b1;
            end
            B_FLUSH: begin
                load             = out_free;
                res.reader_valid = 1'b1;
                res.reader_byte  = at_end ? CHR_LF : rd_data_reg;
                res.echo_valid   = (ptr_reg == '0) && cur_reg.echo;
                res.echo_byte    = ((ptr_reg == '0) && cur_reg.echo) ? CHR_LF : 8'h00;
                res.last         = at_end;
                if (out_free) begin
                    ptr_next = ptr_reg + 1'b1;
                    rd_addr  = ptr_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        ptr_reg <= ptr_next;
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[head_cmd.idx[IDX_W-1:0]] <= head_cmd.data;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/terminal_line_discipline.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline: canonical terminal input processing
// Applies signal characters, line editing with backspace, newline flush
// and echo to a stream of typed bytes.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake          | Payload
//  s_      | in  | s_tvalid/s_tready  | tdata: in_byte; tlast: end_of_write
//  m_      | out | m_tvalid/m_tready  | tdata: result fields; tlast: last
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A byte with a single result passes through the back-end states B_IDLE,
//  which pops its command, and B_ONE, which loads the output register; a
//  signal with echo adds B_SIG2. A flush yields the line bytes and a newline
//  at one beat per cycle unless stalled, set by the single store read port.
//  Reset is synchronous; the line starts empty and the line store needs no
//  clearing. A stalled output holds the back end; the front end keeps taking
//  bytes until its two-entry command queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_discipline #(
    parameter int LINE_BYTES = tld_pkg::LINE_BYTES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] in_byte
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] reader_valid, [8:1] reader_byte, [9] echo_valid, [17:10] echo_byte,
    // [19:18] raise_signal, [23:20] zero
    output logic [tld_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import tld_pkg::*;

    queue_status_t q_status;
    cmd_t          push_cmd;
    cmd_t          head_cmd;
    logic          push;
    logic          pop;
    result_t       result;

    // End of write has no effect on processing.
    logic unused_tlast;
    assign unused_tlast = s_tlast;

    tld_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tld_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    tld_back #(
        .LINE_BYTES(LINE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    // Pack the result beat.
    assign m_tdata = {4'b0000, result.sig, result.echo_byte, result.echo_valid,
                      result.reader_byte, result.reader_valid};
    assign m_tlast = result.last;

endmodule

`default_nettype wire

FILE: rtl/core/tld_checker.sv
// ----------------------------------------------------------------------------
// tld_checker: port-level checks of the terminal line discipline
// Watches the result channel and flags malformed or unstable beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tld_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [tld_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                        m_tlast
);

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Byte fields read as zero when their valid flags are low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || (m_tdata[8:1] == 8'h00)) &&
                     (m_tdata[9] || (m_tdata[17:10] == 8'h00)))
        else $error("byte field set without its valid flag");

    // A signal beat never carries a reader byte and never an unknown code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[19:18] != 2'b00) |-> !m_tdata[0] && (m_tdata[19:18] != 2'b11))
        else $error("malformed signal beat");

    // A signal beat with echo is never a last; its second beat must follow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[19:18] != 2'b00) && m_tdata[9] |-> !m_tlast)
        else $error("signal echo ended early");

endmodule

bind terminal_line_discipline tld_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
